// ===== hw/rtl/utf8_stream_validate_width_core_defines.svh =====
// Assertion macros used by the checker file of the UTF-8 validator.
`ifndef UTF8_STREAM_VALIDATE_WIDTH_CORE_DEFINES_SVH
`define UTF8_STREAM_VALIDATE_WIDTH_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U8V_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define U8V_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/u8v_pkg.sv =====
// Package with types and constants of the UTF-8 stream validator.
package u8v_pkg;

  localparam int unsigned CpW   = 21;
  localparam int unsigned LenW  = 3;
  localparam int unsigned WidW  = 2;
  localparam int unsigned PendW = 2;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_A_LOW  = 2'd0,
    CFG_A_HIGH = 2'd1,
    CFG_B_LOW  = 2'd2,
    CFG_B_HIGH = 2'd3
  } cfg_idx_e;

  localparam logic [CpW-1:0] A_LOW_RST  = 21'h001100;
  localparam logic [CpW-1:0] A_HIGH_RST = 21'h00115F;
  localparam logic [CpW-1:0] B_LOW_RST  = 21'h01F300;
  localparam logic [CpW-1:0] B_HIGH_RST = 21'h01F64F;

  // Display widths.
  localparam logic [WidW-1:0] WID_NONE   = 2'd0;
  localparam logic [WidW-1:0] WID_NARROW = 2'd1;
  localparam logic [WidW-1:0] WID_WIDE   = 2'd2;

  // Sequence lengths.
  localparam logic [LenW-1:0] LEN_NONE = 3'd0;
  localparam logic [LenW-1:0] LEN_ONE  = 3'd1;
  localparam logic [LenW-1:0] LEN_TWO  = 3'd2;
  localparam logic [LenW-1:0] LEN_THREE = 3'd3;
  localparam logic [LenW-1:0] LEN_FOUR = 3'd4;

  typedef struct packed {
    logic [CpW-1:0] a_low;
    logic [CpW-1:0] a_high;
    logic [CpW-1:0] b_low;
    logic [CpW-1:0] b_high;
  } wide_cfg_t;

  typedef struct packed {
    logic            done;
    logic [CpW-1:0]  cp;
    logic [LenW-1:0] len;
    logic            err;
    logic            last;
    logic            valid;
  } dec_res_t;

endpackage

// ===== hw/rtl/u8v_cfg_regs.sv =====
// Configuration registers holding the two double-width code point ranges.
module u8v_cfg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_index_i,
  input  logic [u8v_pkg::CpW-1:0]   cfg_wdata_i,
  output u8v_pkg::wide_cfg_t        cfg_o
);
  import u8v_pkg::*;

  wide_cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_A_LOW:  cfg_d.a_low  = cfg_wdata_i;
        CFG_A_HIGH: cfg_d.a_high = cfg_wdata_i;
        CFG_B_LOW:  cfg_d.b_low  = cfg_wdata_i;
        CFG_B_HIGH: cfg_d.b_high = cfg_wdata_i;
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.a_low  <= A_LOW_RST;
      cfg_q.a_high <= A_HIGH_RST;
      cfg_q.b_low  <= B_LOW_RST;
      cfg_q.b_high <= B_HIGH_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/u8v_decode.sv =====
// UTF-8 sequence decoder with per-string state and sticky error tracking.
module u8v_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  output u8v_pkg::dec_res_t   res_o
);
  import u8v_pkg::*;

  logic [PendW-1:0] pend_d, pend_q;
  logic [CpW-1:0]   acc_d, acc_q;
  logic [LenW-1:0]  len_d, len_q;
  logic             err_d, err_q;
  dec_res_t         res;

  always_comb begin
    pend_d = pend_q;
    acc_d  = acc_q;
    len_d  = len_q;
    err_d  = err_q;
    res    = '0;

    if (!err_q) begin
      if (pend_q == '0) begin
        if (!byte_i[7]) begin
          res.done = 1'b1;
          res.cp   = {13'd0, byte_i};
          res.len  = LEN_ONE;
        end else if (byte_i[7:5] == 3'b110) begin
          acc_d  = {16'd0, byte_i[4:0]};
          len_d  = LEN_TWO;
          pend_d = 2'd1;
        end else if (byte_i[7:4] == 4'b1110) begin
          acc_d  = {17'd0, byte_i[3:0]};
          len_d  = LEN_THREE;
          pend_d = 2'd2;
        end else if (byte_i[7:3] == 5'b11110) begin
          acc_d  = {18'd0, byte_i[2:0]};
          len_d  = LEN_FOUR;
          pend_d = 2'd3;
        end else begin
          err_d = 1'b1;
        end
      end else if (byte_i[7:6] != 2'b10) begin
        // A broken continuation drops the sequence in progress.
        err_d  = 1'b1;
        pend_d = '0;
        acc_d  = '0;
        len_d  = LEN_NONE;
      end else begin
        acc_d  = {acc_q[CpW-7:0], byte_i[5:0]};
        pend_d = pend_q - 2'd1;
        if (pend_d == '0) begin
          res.done = 1'b1;
          res.cp   = acc_d;
          res.len  = len_q;
          acc_d    = '0;
          len_d    = LEN_NONE;
        end
      end
    end

    res.err  = err_d;
    res.last = last_i;
    if (last_i) begin
      // A sequence cut short by the end of the string is an error.
      if (pend_d != '0) begin
        res.err = 1'b1;
      end
      res.valid = !res.err;
      pend_d = '0;
      acc_d  = '0;
      len_d  = LEN_NONE;
      err_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      acc_q  <= '0;
      len_q  <= LEN_NONE;
      err_q  <= 1'b0;
    end else if (step_i) begin
      pend_q <= pend_d;
      acc_q  <= acc_d;
      len_q  <= len_d;
      err_q  <= err_d;
    end
  end

  assign res_o = res;

endmodule

// ===== hw/rtl/u8v_width.sv =====
// Display width classifier comparing a code point against two wide ranges.
module u8v_width (
  input  logic                      done_i,
  input  logic [u8v_pkg::CpW-1:0]   cp_i,
  input  u8v_pkg::wide_cfg_t        cfg_i,
  output logic [u8v_pkg::WidW-1:0]  width_o
);
  import u8v_pkg::*;

  logic in_a, in_b;

  // An empty range (low above high) never matches.
  assign in_a = (cp_i >= cfg_i.a_low) && (cp_i <= cfg_i.a_high);
  assign in_b = (cp_i >= cfg_i.b_low) && (cp_i <= cfg_i.b_high);

  always_comb begin
    if (!done_i) begin
      width_o = WID_NONE;
    end else if (in_a || in_b) begin
      width_o = WID_WIDE;
    end else begin
      width_o = WID_NARROW;
    end
  end

endmodule

// ===== hw/rtl/utf8_stream_validate_width_core.sv =====
// Top level of the UTF-8 stream validator and display width classifier.
// Throughput: one byte per cycle while output is not stalled, with decode and width
// compare between two registers, the input register and the output register.
// The output register lets the next byte enter while a result waits to be taken.
// Reset (asynchronous, active low) clears the pipeline and the per-string decoder
// state and loads the wide ranges with their default values.
module utf8_stream_validate_width_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Configuration write port.
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_index_i,
  input  logic [u8v_pkg::CpW-1:0]   cfg_wdata_i,
  // Byte input channel.
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                data_byte_i,
  input  logic                      end_of_string_i,
  // Result output channel.
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      char_done_o,
  output logic [u8v_pkg::CpW-1:0]   code_point_o,
  output logic [u8v_pkg::LenW-1:0]  char_bytes_o,
  output logic [u8v_pkg::WidW-1:0]  display_width_o,
  output logic                      error_seen_o,
  output logic                      string_done_o,
  output logic                      string_valid_o
);
  import u8v_pkg::*;

  // Input register stage.
  logic       in_vld_d, in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // Output register stage.
  logic             out_vld_d, out_vld_q;
  logic             out_done_q;
  logic [CpW-1:0]   out_cp_q;
  logic [LenW-1:0]  out_len_q;
  logic [WidW-1:0]  out_wid_q;
  logic             out_err_q;
  logic             out_last_q;
  logic             out_valid_str_q;

  logic             out_space;
  logic             advance;
  logic             in_xfer;
  wide_cfg_t        wide_cfg;
  dec_res_t         dec_res;
  logic [WidW-1:0]  dec_wid;

  // The output register can take a result when it is empty or being drained.
  assign out_space  = !out_vld_q || out_ready_i;
  // The held byte moves into the decoder and its result into the output register.
  assign advance    = in_vld_q && out_space;
  // The input register accepts a new byte when empty or emptying this cycle.
  assign in_ready_o = !in_vld_q || out_space;
  assign in_xfer    = in_valid_i && in_ready_o;

  u8v_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (wide_cfg)
  );

  // Decoder state steps only when a byte actually moves to the output side.
  u8v_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .res_o  (dec_res)
  );

  u8v_width u_width (
    .done_i  (dec_res.done),
    .cp_i    (dec_res.cp),
    .cfg_i   (wide_cfg),
    .width_o (dec_wid)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_xfer) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers carry no reset; their valid flags qualify them.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q <= data_byte_i;
      in_last_q <= end_of_string_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_done_q      <= dec_res.done;
      out_cp_q        <= dec_res.cp;
      out_len_q       <= dec_res.len;
      out_wid_q       <= dec_wid;
      out_err_q       <= dec_res.err;
      out_last_q      <= dec_res.last;
      out_valid_str_q <= dec_res.valid;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign char_done_o     = out_done_q;
  assign code_point_o    = out_cp_q;
  assign char_bytes_o    = out_len_q;
  assign display_width_o = out_wid_q;
  assign error_seen_o    = out_err_q;
  assign string_done_o   = out_last_q;
  assign string_valid_o  = out_valid_str_q;

endmodule

// ===== hw/rtl/u8v_checker.sv =====
// Port-level checker for the UTF-8 validator, bound to the top level.
`include "utf8_stream_validate_width_core_defines.svh"

module u8v_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic                      char_done_o,
  input logic [u8v_pkg::CpW-1:0]   code_point_o,
  input logic [u8v_pkg::LenW-1:0]  char_bytes_o,
  input logic [u8v_pkg::WidW-1:0]  display_width_o,
  input logic                      error_seen_o,
  input logic                      string_done_o,
  input logic                      string_valid_o
);
  import u8v_pkg::*;

  `U8V_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(code_point_o) && $stable(error_seen_o), "stalled result changed")
  `U8V_ASSERT_IMP(a_char_fields, clk_i, rst_ni, out_valid_o && char_done_o, char_bytes_o != LEN_NONE && display_width_o != WID_NONE, "completed character lacks length or width")
  `U8V_ASSERT_IMP(a_no_char_zero, clk_i, rst_ni, out_valid_o && !char_done_o, code_point_o == '0 && char_bytes_o == LEN_NONE && display_width_o == WID_NONE, "fields set without a completed character")
  `U8V_ASSERT_IMP(a_valid_no_err, clk_i, rst_ni, out_valid_o && string_valid_o, string_done_o && !error_seen_o, "string reported valid with an error or before its end")

endmodule

bind utf8_stream_validate_width_core u8v_checker u_u8v_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .char_done_o     (char_done_o),
  .code_point_o    (code_point_o),
  .char_bytes_o    (char_bytes_o),
  .display_width_o (display_width_o),
  .error_seen_o    (error_seen_o),
  .string_done_o   (string_done_o),
  .string_valid_o  (string_valid_o)
);

// ===== dv/tb.sv =====
// Self-checking testbench for the UTF-8 stream validator and display width classifier.
module tb;
  import u8v_pkg::*;

  // The run ends here if the block stops moving.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // Bytes of random strings queued at least in each configuration phase.
  localparam int unsigned PHASE_BYTES = 280;
  localparam int unsigned PHASES = 6;
  // Cycles that wait_drained lets pass after every result has been checked.
  localparam int unsigned SETTLE_CYCLES = 4;

  // Directed strings, listed first to last. Bit 8 flags the final byte of a string.
  localparam logic [24:0][8:0] DIRECTED_BYTES = {
    // Zero byte, top of ASCII, then a two-byte character.
    9'h000, 9'h07F, 9'h0C2, 9'h1A9,
    // Last code point of wide range A and first of wide range B.
    9'h0E1, 9'h085, 9'h09F, 9'h0F0, 9'h09F, 9'h08C, 9'h180,
    // Four-byte form with every payload bit set.
    9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF,
    // Invalid lead byte; the error must stick through the ASCII byte after it.
    9'h0FF, 9'h141,
    // Lead byte followed by something that is not a continuation.
    9'h0C3, 9'h141,
    // Three-byte sequence cut short by the end of the string.
    9'h0E2, 9'h182,
    // Lone continuation byte, then the five-byte lead pattern.
    9'h180, 9'h1F8,
    // Overlong two-byte zero, which is accepted.
    9'h0C0, 9'h180
  };

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } byte_item_t;

  typedef struct packed {
    logic            done;
    logic [CpW-1:0]  cp;
    logic [LenW-1:0] len;
    logic [WidW-1:0] wid;
    logic            err;
    logic            last;
    logic            valid;
  } utf8_res_t;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              cfg_we_i        = 1'b0;
  logic [1:0]        cfg_index_i     = CFG_A_LOW;
  logic [CpW-1:0]    cfg_wdata_i     = '0;
  logic              in_valid_i      = 1'b0;
  logic              in_ready_o;
  logic [7:0]        data_byte_i     = '0;
  logic              end_of_string_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i     = 1'b0;
  logic              char_done_o;
  logic [CpW-1:0]    code_point_o;
  logic [LenW-1:0]   char_bytes_o;
  logic [WidW-1:0]   display_width_o;
  logic              error_seen_o;
  logic              string_done_o;
  logic              string_valid_o;

  utf8_stream_validate_width_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .end_of_string_i(end_of_string_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .char_done_o    (char_done_o),
    .code_point_o   (code_point_o),
    .char_bytes_o   (char_bytes_o),
    .display_width_o(display_width_o),
    .error_seen_o   (error_seen_o),
    .string_done_o  (string_done_o),
    .string_valid_o (string_valid_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Testbench copy of the wide ranges, indexed by register.
  logic [CpW-1:0] wide_bound [4] = '{A_LOW_RST, A_HIGH_RST, B_LOW_RST, B_HIGH_RST};

  // Decoder state of the string in progress, as the block should hold it.
  logic [PendW-1:0] dec_pending = '0;
  logic [CpW-1:0]   dec_accum   = '0;
  logic [LenW-1:0]  dec_len     = LEN_NONE;
  logic             dec_err     = 1'b0;

  byte_item_t  string_bytes [$];  // bytes waiting to be offered to the block
  utf8_res_t   decoded_q [$];     // predicted results, oldest first

  int unsigned bytes_queued   = 0;
  int unsigned bytes_sent     = 0;
  int unsigned bytes_taken    = 0;
  int unsigned results_seen   = 0;
  int unsigned chars_seen     = 0;
  int unsigned wide_seen      = 0;
  int unsigned strings_seen   = 0;
  int unsigned strings_broken = 0;
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;

  // While calm is set neither side idles, so some stretches run at full rate.
  logic        calm     = 1'b0;
  int unsigned in_gap   = 0;
  int unsigned out_stall = 0;

  // Mostly short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Advances the decoder by one byte and returns the result the block must give for it.
  // Once an error is flagged, the rest of the string decodes nothing. A final byte
  // that leaves continuations pending marks the string invalid, and every final
  // byte returns the decoder to its idle state.
  function automatic utf8_res_t decode_byte(input logic [7:0] b, input logic is_last);
    utf8_res_t r;
    r = '0;
    if (!dec_err) begin
      if (dec_pending == 0) begin
        if (b[7] == 1'b0) begin
          r.done = 1'b1;
          r.cp   = {13'd0, b};
          r.len  = LEN_ONE;
        end else if (b[7:5] == 3'b110) begin
          dec_accum   = {16'd0, b[4:0]};
          dec_len     = LEN_TWO;
          dec_pending = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          dec_accum   = {17'd0, b[3:0]};
          dec_len     = LEN_THREE;
          dec_pending = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          dec_accum   = {18'd0, b[2:0]};
          dec_len     = LEN_FOUR;
          dec_pending = 2'd3;
        end else begin
          dec_err = 1'b1;
        end
      end else if (b[7:6] != 2'b10) begin
        dec_err     = 1'b1;
        dec_pending = '0;
        dec_accum   = '0;
        dec_len     = LEN_NONE;
      end else begin
        dec_accum   = {dec_accum[CpW-7:0], b[5:0]};
        dec_pending = dec_pending - 2'd1;
        if (dec_pending == 0) begin
          r.done    = 1'b1;
          r.cp      = dec_accum;
          r.len     = dec_len;
          dec_accum = '0;
          dec_len   = LEN_NONE;
        end
      end
    end

    // Bounds are inclusive; a range whose low end lies above its high end is empty.
    if (!r.done) begin
      r.wid = WID_NONE;
    end else if ((r.cp >= wide_bound[CFG_A_LOW] && r.cp <= wide_bound[CFG_A_HIGH]) ||
                 (r.cp >= wide_bound[CFG_B_LOW] && r.cp <= wide_bound[CFG_B_HIGH])) begin
      r.wid = WID_WIDE;
    end else begin
      r.wid = WID_NARROW;
    end

    r.err  = dec_err;
    r.last = is_last;
    if (is_last) begin
      if (dec_pending != 0) r.err = 1'b1;
      r.valid     = !r.err;
      dec_pending = '0;
      dec_accum   = '0;
      dec_len     = LEN_NONE;
      dec_err     = 1'b0;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [CpW-1:0] want,
                             input logic [CpW-1:0] got);
    if (got !== want) begin
      $error("tb: %s expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic is_last);
    byte_item_t item;
    item = '{data: b, is_last: is_last};
    string_bytes.push_back(item);
    bytes_queued++;
  endtask

  // Queues the first count bytes of the n-byte encoding of cp. A count below n
  // leaves the sequence unfinished. Encoding bits that cp does not fill come out
  // as given, so overlong forms appear too.
  task automatic push_char(input logic [CpW-1:0] cp, input int unsigned n,
                           input int unsigned count);
    logic [7:0] b;
    for (int unsigned k = 0; k < count; k++) begin
      if (k == 0) begin
        case (n)
          1:       b = {1'b0, cp[6:0]};
          2:       b = {3'b110, cp[10:6]};
          3:       b = {4'b1110, cp[15:12]};
          default: b = {5'b11110, cp[20:18]};
        endcase
      end else begin
        b = {2'b10, cp[6*(n-1-k) +: 6]};
      end
      push_byte(b, 1'b0);
    end
  endtask

  // Builds one string: mostly well-formed characters, some of them right at the
  // edges of the wide ranges, with stray bytes, unfinished sequences and broken
  // continuations mixed in. The final byte carries the end flag.
  task automatic add_random_string();
    int unsigned nchars;
    int unsigned kind;
    int unsigned n;
    logic [CpW-1:0] cp;
    logic [7:0] bad;
    byte_item_t tail;
    nchars = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
    repeat (nchars) begin
      kind = $urandom_range(0, 99);
      n    = $urandom_range(2, 4);
      cp   = CpW'($urandom);
      if (kind < 80) begin
        if ($urandom_range(0, 1) == 1) begin
          cp = wide_bound[$urandom_range(0, 3)] + CpW'($urandom_range(0, 4)) - CpW'(2);
          n  = (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
        end else begin
          n = $urandom_range(1, 4);
        end
        push_char(cp, n, n);
      end else if (kind < 86) begin
        push_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (kind < 93) begin
        push_char(cp, n, $urandom_range(1, n - 1));
      end else begin
        push_char(cp, n, $urandom_range(1, n - 1));
        bad = 8'($urandom_range(0, 255));
        if (bad[7:6] == 2'b10) bad[7:6] = ($urandom_range(0, 1) == 1) ? 2'b11 : 2'b00;
        push_byte(bad, 1'b0);
      end
    end
    tail = string_bytes.pop_back();
    tail.is_last = 1'b1;
    string_bytes.push_back(tail);
  endtask

  // Writes all four range registers, one per cycle. Only called while the block is idle.
  task automatic write_ranges(input logic [CpW-1:0] a_lo, input logic [CpW-1:0] a_hi,
                              input logic [CpW-1:0] b_lo, input logic [CpW-1:0] b_hi);
    logic [CpW-1:0] vals [4];
    cfg_idx_e idx;
    vals = '{a_lo, a_hi, b_lo, b_hi};
    idx  = idx.first();
    repeat (4) begin
      @(negedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx;
      cfg_wdata_i <= vals[idx];
      wide_bound[idx] = vals[idx];
      idx = idx.next();
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Returns once every queued byte is taken and every result has been checked,
  // then lets the pipeline settle.
  task automatic wait_drained();
    while (string_bytes.size() != 0 || bytes_sent != bytes_taken || decoded_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Byte driver. A byte stays on the bus until its transfer; after that the next
  // one follows at once or after a random gap.
  always @(negedge clk_i) begin : byte_driver
    byte_item_t item;
    if (rst_ni && (!in_valid_i || bytes_sent == bytes_taken)) begin
      if (in_gap > 0) begin
        in_gap     <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (string_bytes.size() != 0) begin
        item = string_bytes.pop_front();
        in_valid_i      <= 1'b1;
        data_byte_i     <= item.data;
        end_of_string_i <= item.is_last;
        bytes_sent      <= bytes_sent + 1;
        in_gap          <= pick_gap();
        if ($urandom_range(0, 199) == 0) calm <= !calm;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver. Stalls fall at random, independent of what the block is doing.
  always @(negedge clk_i) begin : result_receiver
    if (rst_ni) begin
      if (out_stall > 0) begin
        out_ready_i <= 1'b0;
        out_stall   <= out_stall - 1;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 2) == 0) out_stall <= pick_gap();
      end
    end
  end

  // Monitor. A result is checked before the byte of the same edge is predicted;
  // with the input and output registers between, that byte cannot be answered now.
  always @(posedge clk_i) begin : monitor
    utf8_res_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (decoded_q.size() == 0) begin
          $error("tb: result transfer with no byte outstanding");
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          check_field("char_done", CpW'(want.done), CpW'(char_done_o));
          check_field("code_point", want.cp, code_point_o);
          check_field("char_bytes", CpW'(want.len), CpW'(char_bytes_o));
          check_field("display_width", CpW'(want.wid), CpW'(display_width_o));
          check_field("error_seen", CpW'(want.err), CpW'(error_seen_o));
          check_field("string_done", CpW'(want.last), CpW'(string_done_o));
          check_field("string_valid", CpW'(want.valid), CpW'(string_valid_o));
          results_seen++;
          if (want.done) chars_seen++;
          if (want.wid == WID_WIDE) wide_seen++;
          if (want.last) strings_seen++;
          if (want.last && !want.valid) strings_broken++;
        end
      end
      if (in_valid_i && in_ready_o) begin
        decoded_q.push_back(decode_byte(data_byte_i, end_of_string_i));
        bytes_taken++;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycle_count);
      $display("tb: errors");
      $finish;
    end
  end

  // Stimulus. The first phase runs on the reset ranges and starts with the
  // directed strings; each later phase loads new ranges while the block is idle:
  // random narrow ranges, everything wide, everything narrow, single-point ranges,
  // and finally the reset values written back.
  initial begin : stimulus
    logic [CpW-1:0] lo_a, hi_a, lo_b, hi_b;
    int unsigned target;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1: begin
          lo_a = CpW'($urandom_range(0, 'hFFFF));
          hi_a = lo_a + CpW'($urandom_range(0, 'hFFF));
          lo_b = CpW'($urandom_range(0, 'h1FFFF));
          hi_b = lo_b + CpW'($urandom_range(0, 'hFFFF));
        end
        2: begin
          // Range A covers the whole code space; range B is empty.
          lo_a = '0;
          hi_a = '1;
          lo_b = '1;
          hi_b = '0;
        end
        3: begin
          // Both ranges empty, so nothing is wide.
          lo_a = '1;
          hi_a = '0;
          lo_b = CpW'(1);
          hi_b = '0;
        end
        4: begin
          lo_a = CpW'('h41);
          hi_a = CpW'('h41);
          lo_b = '1;
          hi_b = '1;
        end
        default: begin
          lo_a = A_LOW_RST;
          hi_a = A_HIGH_RST;
          lo_b = B_LOW_RST;
          hi_b = B_HIGH_RST;
        end
      endcase

      if (ph == 0) begin
        for (int i = 24; i >= 0; i--)
          push_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8]);
      end else begin
        write_ranges(lo_a, hi_a, lo_b, hi_b);
      end

      target = bytes_queued + PHASE_BYTES;
      while (bytes_queued < target) add_random_string();
      wait_drained();
    end

    $display("tb: %0d bytes checked over %0d strings, %0d of them invalid",
             results_seen, strings_seen, strings_broken);
    $display("tb: %0d characters decoded, %0d double width, across %0d range settings",
             chars_seen, wide_seen, PHASES);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
